@@ src/breakpoint_address_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// breakpoint address table assertion macros
// shared assertion shorthands, clocked on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ADDRESS_TABLE_TOP_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define BAT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition implies consequence on the next edge
`define BAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bat_pkg.sv @@
// ----------------------------------------------------------------------------
// bat_pkg
// types, constants and control structs of the breakpoint address table
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int ADDR_WIDTH_DEF = 16;

	localparam int OP_W      = 2;
	localparam int IN_ADDR_W = 16;
	localparam int COUNT_W   = 7;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic append;
		logic clr;
		logic remove;
		logic move_wr;
		logic set_err;
		logic err_val;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_done;
		logic hit;
		logic full;
		logic out_free;
	} stat_t;

endpackage

@@ src/bat_ram.sv @@
// ----------------------------------------------------------------------------
// bat_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module bat_ram #(
	parameter int WIDTH = bat_pkg::ADDR_WIDTH_DEF,
	parameter int DEPTH = bat_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/bat_ctrl.sv @@
// ----------------------------------------------------------------------------
// bat_ctrl
// sequencer for accept, scan, update and response of one item
// ----------------------------------------------------------------------------
module bat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  bat_pkg::stat_t stat,
	output bat_pkg::cmd_t  cmd
);

	bat_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bat_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = bat_pkg::ST_SCAN;
				end
			end
			bat_pkg::ST_SCAN: begin
				if (stat.op == bat_pkg::OP_CLEAR || stat.scan_done) begin
					state_d = bat_pkg::ST_DECIDE;
				end
			end
			bat_pkg::ST_DECIDE: begin
				if (stat.op == bat_pkg::OP_REMOVE && stat.hit) begin
					state_d = bat_pkg::ST_MOVE_WR;
				end else begin
					state_d = bat_pkg::ST_RESP;
				end
			end
			bat_pkg::ST_MOVE_WR: begin
				state_d = bat_pkg::ST_RESP;
			end
			bat_pkg::ST_RESP: begin
				if (stat.out_free) begin
					state_d = bat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bat_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			bat_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			bat_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			bat_pkg::ST_DECIDE: begin
				cmd.set_err = 1'b1;
				case (stat.op)
					bat_pkg::OP_ADD: begin
						if (!stat.hit) begin
							if (stat.full) begin
								cmd.err_val = 1'b1;
							end else begin
								cmd.append = 1'b1;
							end
						end
					end
					bat_pkg::OP_REMOVE: begin
						if (stat.hit) begin
							cmd.remove = 1'b1;
						end else begin
							cmd.err_val = 1'b1;
						end
					end
					bat_pkg::OP_CLEAR: begin
						cmd.clr = 1'b1;
					end
					default: begin
						cmd.err_val = 1'b0;
					end
				endcase
			end
			bat_pkg::ST_MOVE_WR: begin
				cmd.move_wr = 1'b1;
			end
			bat_pkg::ST_RESP: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ src/bat_datapath.sv @@
// ----------------------------------------------------------------------------
// bat_datapath
// entry ram, valid count, sequential match scan and output register
// ----------------------------------------------------------------------------
`include "breakpoint_address_table_top_macros.svh"

module bat_datapath #(
	parameter int DEPTH      = bat_pkg::DEPTH_DEF,
	parameter int ADDR_WIDTH = bat_pkg::ADDR_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bat_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bat_pkg::M_TDATA_W-1:0]   m_tdata,
	input  bat_pkg::cmd_t                   cmd,
	output bat_pkg::stat_t                  stat
);

	localparam int IDX_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	bat_pkg::op_t          op_q;
	logic [ADDR_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      last_idx;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic                  cmp_vld_q;
	logic [IDX_W-1:0]      slot_q;
	logic                  hit_q;
	logic                  err_q;
	logic                  match;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ADDR_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ADDR_WIDTH-1:0] ram_rdata;

	logic                  out_vld_q;
	logic                  out_status_q;
	logic                  out_hit_q;
	logic [bat_pkg::COUNT_W-1:0] out_count_q;

	assign last_idx = cnt_q - 1'b1;
	assign match    = cmp_vld_q && (ram_rdata == key_q);

	always_comb begin
		ram_raddr = cmd.remove ? last_idx[IDX_W-1:0] : rd_ptr_q[IDX_W-1:0];
		ram_we    = cmd.append || cmd.move_wr;
		ram_waddr = cmd.move_wr ? slot_q : cnt_q[IDX_W-1:0];
		ram_wdata = cmd.move_wr ? ram_rdata : key_q;
	end

	bat_ram #(
		.WIDTH(ADDR_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= bat_pkg::op_t'(s_tdata[bat_pkg::OP_W-1:0]);
			key_q <= ADDR_WIDTH'(s_tdata[bat_pkg::OP_W +: bat_pkg::IN_ADDR_W]);
		end
		if (cmd.scan_step) begin
			cmp_idx_q <= rd_ptr_q[IDX_W-1:0];
		end
		if (match) begin
			slot_q <= cmp_idx_q;
		end
		if (cmd.set_err) begin
			err_q <= cmd.err_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_ptr_q  <= '0;
			cmp_vld_q <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.accept) begin
				rd_ptr_q  <= '0;
				cmp_vld_q <= 1'b0;
				hit_q     <= 1'b0;
			end else if (cmd.scan_step) begin
				if (rd_ptr_q < cnt_q) begin
					rd_ptr_q  <= rd_ptr_q + 1'b1;
					cmp_vld_q <= 1'b1;
				end else begin
					cmp_vld_q <= 1'b0;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.remove) begin
				cnt_q <= last_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= err_q;
			out_hit_q    <= (op_q == bat_pkg::OP_QUERY) && hit_q;
			out_count_q  <= bat_pkg::COUNT_W'(cnt_q);
		end
	end

	always_comb begin
		stat.op        = op_q;
		stat.scan_done = match || (!cmp_vld_q && rd_ptr_q >= cnt_q);
		stat.hit       = hit_q;
		stat.full      = cnt_q == DEPTH_C;
		stat.out_free  = !out_vld_q || m_tready;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = bat_pkg::M_TDATA_W'({out_count_q, out_hit_q, out_status_q});

	`BAT_ASSERT_ALWAYS(a_cnt_range, cnt_q <= DEPTH_C, "entry count beyond table depth")
	`BAT_ASSERT_ALWAYS(a_append_room, !cmd.append || cnt_q < DEPTH_C, "append into a full table")
	`BAT_ASSERT_ALWAYS(a_remove_hit, !cmd.remove || (hit_q && cnt_q != '0), "remove without a match")
	`BAT_ASSERT_NEXT(a_load_valid, cmd.load_out, out_vld_q, "loaded result not presented")

endmodule

@@ src/breakpoint_address_table_top.sv @@
// ----------------------------------------------------------------------------
// breakpoint_address_table_top
// breakpoint word address table with add, remove, query and clear
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata[1:0] operation, [17:2] address
// m_*      out  m_tvalid/m_tready  tdata[0] status, [1] hit, [8:2] count
//
// one item at a time; after accept the item passes the scan, decide and response steps,
// the scan ending on the first match or once all valid entries are read
// a remove that hits adds a move step; clear and an empty table compare no entry
// the match scan reads one ram entry per cycle through the registered port
// reset empties the table at once; ram contents stay undefined until written
// a stalled result waits in the output register and stalls the next item at its response step
// ----------------------------------------------------------------------------
module breakpoint_address_table_top #(
	parameter int DEPTH      = bat_pkg::DEPTH_DEF,
	parameter int ADDR_WIDTH = bat_pkg::ADDR_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bat_pkg::S_TDATA_W-1:0] s_tdata,  // operation, address
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bat_pkg::M_TDATA_W-1:0] m_tdata   // status, hit, count
);

	bat_pkg::cmd_t  cmd;
	bat_pkg::stat_t stat;

	bat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bat_datapath #(
		.DEPTH     (DEPTH),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule
